### hw/rtl/casefold_text_search_boxes_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the case-folding text search block
// Shared concurrent check forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CASEFOLD_TEXT_SEARCH_BOXES_DEFINES_SVH
`define CASEFOLD_TEXT_SEARCH_BOXES_DEFINES_SVH

// same-cycle implication
`define CFTS_ASSERT_NOW(name, clk_s, rst_n_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFTS_ASSERT_NEXT(name, clk_s, rst_n_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cfts_pkg.sv
// ----------------------------------------------------------------------------
// cfts_pkg
// Types, constants and helpers shared by the text search block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfts_pkg;

	localparam int unsigned CFTS_MAX_PATTERN = 32;
	localparam int unsigned CFTS_COORD_BITS  = 24;

	localparam int unsigned CODE_W     = 21;
	localparam int unsigned PLEN_W     = 6;
	localparam int unsigned PIDX_W     = 5;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// input item kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_PATTERN = 2'd0,
		MODE_TEXT    = 2'd1,
		MODE_PAGE    = 2'd2
	} cfts_mode_t;

	// register index, taken from paddr[2]
	localparam logic REG_PATTERN_LENGTH = 1'b0;

	localparam logic [CODE_W-1:0] CHAR_UPPER_A = 21'h41;
	localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 21'h5A;
	localparam logic [CODE_W-1:0] CASE_OFFSET  = 21'h20;

	typedef enum logic {
		LD_IDLE,
		LD_FILL
	} cfts_ld_state_t;

	typedef struct packed {
		logic shift;     // text glyph transfer: window moves one place
		logic clear;     // new page
		logic pat_shift; // aligned pattern chain moves one place
	} cfts_cell_ctl_t;

	typedef struct packed {
		logic busy;
		logic stale;
	} cfts_ld_status_t;

	function automatic logic [CODE_W-1:0] fold_code(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/cfts_ifs.sv
// ----------------------------------------------------------------------------
// cfts interfaces
// Glyph input channel and match result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfts_glyph_if
	import cfts_pkg::*;
	#(parameter int unsigned COORD_BITS = CFTS_COORD_BITS);
	logic                         valid;
	logic                         ready;
	logic [MODE_W-1:0]            mode;
	logic [PIDX_W-1:0]            pattern_index;
	logic [CODE_W-1:0]            code;
	logic                         has_box;
	logic signed [COORD_BITS-1:0] left;
	logic signed [COORD_BITS-1:0] top;
	logic signed [COORD_BITS-1:0] right;
	logic signed [COORD_BITS-1:0] bottom;

	modport source(output valid, mode, pattern_index, code, has_box, left, top, right,
		bottom, input ready);
	modport sink(input valid, mode, pattern_index, code, has_box, left, top, right,
		bottom, output ready);
endinterface

interface cfts_match_if
	import cfts_pkg::*;
	#(parameter int unsigned COORD_BITS = CFTS_COORD_BITS);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] match_left;
	logic signed [COORD_BITS-1:0] match_top;
	logic signed [COORD_BITS-1:0] match_right;
	logic signed [COORD_BITS-1:0] match_bottom;
	logic                         box_found;

	modport source(output valid, match_left, match_top, match_right, match_bottom,
		box_found, input ready);
	modport sink(input valid, match_left, match_top, match_right, match_bottom,
		box_found, output ready);
endinterface

`default_nettype wire

### hw/rtl/cfts_cell.sv
// ----------------------------------------------------------------------------
// cfts_cell
// One window position: folded glyph code, aligned pattern code and the box
// union of the newest IDX+1 glyphs. Each cell takes its neighbor's state.
// ----------------------------------------------------------------------------
`default_nettype none

module cfts_cell
	import cfts_pkg::*;
	#(
	parameter int unsigned COORD_BITS = CFTS_COORD_BITS,
	parameter int unsigned LEN_W      = $clog2(CFTS_MAX_PATTERN + 1),
	parameter int unsigned IDX        = 0
	) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cfts_cell_ctl_t               ctl,
	input  wire logic [LEN_W-1:0]             len,
	// box of the glyph being shifted in, broadcast to every cell
	input  wire logic                         nb_present,
	input  wire logic signed [COORD_BITS-1:0] nb_l,
	input  wire logic signed [COORD_BITS-1:0] nb_t,
	input  wire logic signed [COORD_BITS-1:0] nb_r,
	input  wire logic signed [COORD_BITS-1:0] nb_b,
	input  wire logic [CODE_W-1:0]            w_in,
	output      logic [CODE_W-1:0]            w_out,
	input  wire logic [CODE_W-1:0]            q_in,
	output      logic [CODE_W-1:0]            q_out,
	input  wire logic                         uf_in,
	input  wire logic signed [COORD_BITS-1:0] ul_in,
	input  wire logic signed [COORD_BITS-1:0] ut_in,
	input  wire logic signed [COORD_BITS-1:0] ur_in,
	input  wire logic signed [COORD_BITS-1:0] ub_in,
	output      logic                         uf_out,
	output      logic signed [COORD_BITS-1:0] ul_out,
	output      logic signed [COORD_BITS-1:0] ut_out,
	output      logic signed [COORD_BITS-1:0] ur_out,
	output      logic signed [COORD_BITS-1:0] ub_out,
	output      logic                         ok
	);

	logic [CODE_W-1:0]            w_q;
	logic [CODE_W-1:0]            q_q;
	logic                         uf_q;
	logic signed [COORD_BITS-1:0] ul_q, ut_q, ur_q, ub_q;

	logic                         nf;
	logic signed [COORD_BITS-1:0] nl, nt, nr, nb;
	logic                         in_use;

	// union of the neighbor's box set with the new box
	always_comb begin
		nf = uf_in | nb_present;
		if (!uf_in) begin
			nl = nb_l;
			nt = nb_t;
			nr = nb_r;
			nb = nb_b;
		end else if (!nb_present) begin
			nl = ul_in;
			nt = ut_in;
			nr = ur_in;
			nb = ub_in;
		end else begin
			nl = (nb_l < ul_in) ? nb_l : ul_in;
			nt = (nb_t < ut_in) ? nb_t : ut_in;
			nr = (nb_r > ur_in) ? nb_r : ur_in;
			nb = (nb_b > ub_in) ? nb_b : ub_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uf_q <= 1'b0;
		end else if (ctl.clear) begin
			uf_q <= 1'b0;
		end else if (ctl.shift) begin
			uf_q <= nf;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			w_q <= '0;
		end else if (ctl.shift) begin
			w_q  <= w_in;
			ul_q <= nl;
			ut_q <= nt;
			ur_q <= nr;
			ub_q <= nb;
		end
		if (ctl.pat_shift) begin
			q_q <= q_in;
		end
	end

	assign in_use = LEN_W'(IDX) < len;
	assign ok     = !in_use || (w_q == q_q);

	assign w_out  = w_q;
	assign q_out  = q_q;
	assign uf_out = uf_q;
	assign ul_out = ul_q;
	assign ut_out = ut_q;
	assign ur_out = ur_q;
	assign ub_out = ub_q;

endmodule

`default_nettype wire

### hw/rtl/cfts_pat_loader.sv
// ----------------------------------------------------------------------------
// cfts_pat_loader
// Pattern store and the sequencer that streams it, first character first,
// into the cell chain so that cell i holds pattern[len-1-i].
// ----------------------------------------------------------------------------
`default_nettype none

module cfts_pat_loader
	import cfts_pkg::*;
	#(
	parameter int unsigned MAX_PATTERN = CFTS_MAX_PATTERN,
	parameter int unsigned LEN_W       = $clog2(CFTS_MAX_PATTERN + 1),
	parameter int unsigned IDX_W       = 5
	) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_addr,
	input  wire logic [CODE_W-1:0] wr_data,
	input  wire logic [LEN_W-1:0]  len,
	input  wire logic              go,
	output      cfts_ld_status_t   status,
	output      logic              shift_en,
	output      logic [CODE_W-1:0] shift_data
	);

	logic [CODE_W-1:0] mem [MAX_PATTERN];

	cfts_ld_state_t    state_q, state_d;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  fill_len_q;
	logic [LEN_W-1:0]  built_len_q;
	logic              pat_dirty_q;
	logic              rd_req;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_addr;
	logic [CODE_W-1:0] rd_data_s1;
	logic              stale;
	logic              start;
	logic              done;

	assign stale = pat_dirty_q || (len != built_len_q);
	assign start = (state_q == LD_IDLE) && go && stale;
	assign done  = (state_q == LD_FILL) && !rd_req && !rd_vld_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			LD_IDLE: begin
				if (go && stale) begin
					state_d = LD_FILL;
				end
			end
			LD_FILL: begin
				if (!rd_req && !rd_vld_s1) begin
					state_d = LD_IDLE;
				end
			end
			default: state_d = LD_IDLE;
		endcase
	end

	always_comb begin
		rd_req = 1'b0;
		status = '{busy: 1'b0, stale: stale};
		case (state_q)
			LD_IDLE: begin
				rd_req = 1'b0;
			end
			LD_FILL: begin
				rd_req      = cnt_q < fill_len_q;
				status.busy = 1'b1;
			end
			default: begin
				rd_req = 1'b0;
			end
		endcase
	end

	assign rd_addr = cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LD_IDLE;
			cnt_q       <= '0;
			fill_len_q  <= '0;
			built_len_q <= '0;
			pat_dirty_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_req;
			if (start) begin
				fill_len_q <= len;
				cnt_q      <= '0;
			end else if (rd_req) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (done) begin
				built_len_q <= fill_len_q;
			end
			if (wr_en) begin
				pat_dirty_q <= 1'b1;
			end else if (start) begin
				pat_dirty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
	end

	assign shift_en   = rd_vld_s1;
	assign shift_data = rd_data_s1;

endmodule

`default_nettype wire

### hw/rtl/casefold_text_search_boxes.sv
// A text glyph transfer marks an evaluation pending; once it fires (held while the output
// is stalled) a match result is registered. One item per cycle while results drain and no
// reload runs; the window chain shifts once per glyph. A pattern write or length change
// reloads the aligned pattern chain (len capped at MAX_PATTERN) before the next text glyph,
// which waits for the reload and any pending evaluation. Reset (async, active low) clears
// length, counters and box flags; the pattern memory holds no reset value.
// ----------------------------------------------------------------------------
// casefold_text_search_boxes
// Case-insensitive substring search over a glyph stream, with match box union.
// ----------------------------------------------------------------------------
`default_nettype none

`include "casefold_text_search_boxes_defines.svh"

module casefold_text_search_boxes
	import cfts_pkg::*;
	#(
	parameter int unsigned MAX_PATTERN = CFTS_MAX_PATTERN,
	parameter int unsigned COORD_BITS  = CFTS_COORD_BITS
	) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready,
	cfts_glyph_if.sink                 glyph_in,
	cfts_match_if.source               match_out
	);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned CMP_W = PLEN_W + LEN_W;

	// ---------------- configuration ----------------
	logic [PLEN_W-1:0] plen_q;
	logic              cfg_wr;
	logic [CMP_W-1:0]  plen_x;
	logic [LEN_W-1:0]  len_eff;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (cfg_wr) begin
			plen_q <= pwdata[PLEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PATTERN_LENGTH) begin
			prdata = {{(APB_DATA_W-PLEN_W){1'b0}}, plen_q};
		end
	end

	assign plen_x  = {{LEN_W{1'b0}}, plen_q};
	assign len_eff = (plen_x > CMP_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
		: plen_x[LEN_W-1:0];

	// ---------------- input decode ----------------
	logic                        accept;
	logic                        txt;
	logic                        clr;
	logic                        wr;
	logic [PIDX_W+IDX_W-1:0]     pidx_x;
	logic [PIDX_W+IDX_W-1:0]     maxp_x;
	logic [CODE_W-1:0]           folded;
	logic                        nb_present;
	logic                        eval_s1;
	logic                        out_valid_q;
	logic                        out_blocked;
	logic                        eval_fire;
	logic                        hit;
	cfts_ld_status_t             ld_st;
	logic                        ld_shift;
	logic [CODE_W-1:0]           ld_data;
	cfts_cell_ctl_t              ctl;

	assign out_blocked = out_valid_q && !match_out.ready;
	assign eval_fire   = eval_s1 && !out_blocked;

	assign glyph_in.ready = !ld_st.busy
		&& !(ld_st.stale && (glyph_in.mode == MODE_TEXT))
		&& !(eval_s1 && out_blocked);

	assign accept = glyph_in.valid && glyph_in.ready;
	assign txt    = accept && (glyph_in.mode == MODE_TEXT);
	assign clr    = accept && (glyph_in.mode == MODE_PAGE);
	assign pidx_x = {{IDX_W{1'b0}}, glyph_in.pattern_index};
	assign maxp_x = (PIDX_W + IDX_W)'(MAX_PATTERN);
	assign wr     = accept && (glyph_in.mode == MODE_PATTERN) && (pidx_x < maxp_x);
	assign folded = fold_code(glyph_in.code);

	assign nb_present = glyph_in.has_box && (glyph_in.left < glyph_in.right)
		&& (glyph_in.top < glyph_in.bottom);

	// ---------------- pattern memory and loader ----------------
	cfts_pat_loader #(
		.MAX_PATTERN(MAX_PATTERN),
		.LEN_W      (LEN_W),
		.IDX_W      (IDX_W)
	) u_loader (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr),
		.wr_addr   (pidx_x[IDX_W-1:0]),
		.wr_data   (folded),
		.len       (len_eff),
		.go        (glyph_in.valid && (glyph_in.mode == MODE_TEXT) && !eval_s1),
		.status    (ld_st),
		.shift_en  (ld_shift),
		.shift_data(ld_data)
	);

	assign ctl = '{shift: txt, clear: clr, pat_shift: ld_shift};

	// ---------------- cell chain ----------------
	logic [CODE_W-1:0]            w_o  [MAX_PATTERN];
	logic [CODE_W-1:0]            q_o  [MAX_PATTERN];
	logic                         uf_o [MAX_PATTERN];
	logic signed [COORD_BITS-1:0] ul_o [MAX_PATTERN];
	logic signed [COORD_BITS-1:0] ut_o [MAX_PATTERN];
	logic signed [COORD_BITS-1:0] ur_o [MAX_PATTERN];
	logic signed [COORD_BITS-1:0] ub_o [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]       ok_vec;

	for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
		logic [CODE_W-1:0]            w_i;
		logic [CODE_W-1:0]            q_i;
		logic                         uf_i;
		logic signed [COORD_BITS-1:0] ul_i, ut_i, ur_i, ub_i;

		if (gi == 0) begin : g_head
			// newest glyph enters here; its union starts from an empty set
			assign w_i  = folded;
			assign q_i  = ld_data;
			assign uf_i = 1'b0;
			assign ul_i = '0;
			assign ut_i = '0;
			assign ur_i = '0;
			assign ub_i = '0;
		end else begin : g_link
			assign w_i  = w_o[gi-1];
			assign q_i  = q_o[gi-1];
			assign uf_i = uf_o[gi-1];
			assign ul_i = ul_o[gi-1];
			assign ut_i = ut_o[gi-1];
			assign ur_i = ur_o[gi-1];
			assign ub_i = ub_o[gi-1];
		end

		cfts_cell #(
			.COORD_BITS(COORD_BITS),
			.LEN_W     (LEN_W),
			.IDX       (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.len       (len_eff),
			.nb_present(nb_present),
			.nb_l      (glyph_in.left),
			.nb_t      (glyph_in.top),
			.nb_r      (glyph_in.right),
			.nb_b      (glyph_in.bottom),
			.w_in      (w_i),
			.w_out     (w_o[gi]),
			.q_in      (q_i),
			.q_out     (q_o[gi]),
			.uf_in     (uf_i),
			.ul_in     (ul_i),
			.ut_in     (ut_i),
			.ur_in     (ur_i),
			.ub_in     (ub_i),
			.uf_out    (uf_o[gi]),
			.ul_out    (ul_o[gi]),
			.ut_out    (ut_o[gi]),
			.ur_out    (ur_o[gi]),
			.ub_out    (ub_o[gi]),
			.ok        (ok_vec[gi])
		);
	end

	// ---------------- match evaluation ----------------
	logic [LEN_W-1:0] seen_q;
	logic [LEN_W-1:0] since_q;
	logic [LEN_W-1:0] len_m1;
	logic [IDX_W-1:0] tap;

	assign len_m1 = len_eff - 1'b1;
	assign tap    = len_m1[IDX_W-1:0];
	assign hit    = eval_fire && (len_eff != '0) && (seen_q >= len_eff)
		&& (since_q >= len_eff) && (&ok_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1     <= 1'b0;
			seen_q      <= '0;
			since_q     <= LEN_W'(MAX_PATTERN);
			out_valid_q <= 1'b0;
		end else begin
			if (txt) begin
				eval_s1 <= 1'b1;
			end else if (eval_fire) begin
				eval_s1 <= 1'b0;
			end

			if (clr) begin
				seen_q <= '0;
			end else if (txt && (seen_q != LEN_W'(MAX_PATTERN))) begin
				seen_q <= seen_q + 1'b1;
			end

			// a match restarts the distance count before the next glyph counts
			if (clr) begin
				since_q <= LEN_W'(MAX_PATTERN);
			end else if (hit) begin
				since_q <= txt ? LEN_W'(1) : '0;
			end else if (txt && (since_q != LEN_W'(MAX_PATTERN))) begin
				since_q <= since_q + 1'b1;
			end

			if (hit) begin
				out_valid_q <= 1'b1;
			end else if (match_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic signed [COORD_BITS-1:0] ml_q, mt_q, mr_q, mb_q;
	logic                         mf_q;

	always_ff @(posedge clk) begin
		if (hit) begin
			mf_q <= uf_o[tap];
			ml_q <= uf_o[tap] ? ul_o[tap] : '0;
			mt_q <= uf_o[tap] ? ut_o[tap] : '0;
			mr_q <= uf_o[tap] ? ur_o[tap] : '0;
			mb_q <= uf_o[tap] ? ub_o[tap] : '0;
		end
	end

	assign match_out.valid        = out_valid_q;
	assign match_out.match_left   = ml_q;
	assign match_out.match_top    = mt_q;
	assign match_out.match_right  = mr_q;
	assign match_out.match_bottom = mb_q;
	assign match_out.box_found    = mf_q;

	// ---------------- checks ----------------
	`CFTS_ASSERT_NOW(a_fill_holds_input, clk, arst_n, ld_st.busy, !glyph_in.ready,
		"glyph transfer during pattern reload")
	`CFTS_ASSERT_NOW(a_no_fill_under_eval, clk, arst_n, eval_s1, !ld_st.busy,
		"pattern reload while a glyph awaits evaluation")
	`CFTS_ASSERT_NEXT(a_hit_restarts_count, clk, arst_n, hit && !accept, since_q == '0,
		"match did not restart the distance count")
	`CFTS_ASSERT_NEXT(a_stall_keeps_eval, clk, arst_n, eval_s1 && out_blocked, eval_s1,
		"pending evaluation dropped while output stalled")
	`CFTS_ASSERT_NOW(a_result_from_hit, clk, arst_n, $rose(out_valid_q), $past(hit),
		"result appeared without a match")

endmodule

`default_nettype wire

### tb/casefold_text_search_boxes_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// casefold_text_search_boxes_tb
// Writes the pattern length over APB, loads patterns over the glyph channel,
// streams boxed glyph pages and checks each match box against a bench window model.
// ----------------------------------------------------------------------------
module casefold_text_search_boxes_tb
	import cfts_pkg::*;
	();

	localparam int unsigned WIN = CFTS_MAX_PATTERN;
	localparam int unsigned CW  = CFTS_COORD_BITS;

	localparam logic [MODE_W-1:0]     MODE_UNUSED         = 2'd3;
	localparam logic [APB_ADDR_W-1:0] PATTERN_LENGTH_ADDR = {REG_PATTERN_LENGTH, 2'b00};

	localparam logic [CODE_W-1:0] CHAR_LOWER_A = CHAR_UPPER_A + CASE_OFFSET;
	localparam logic [CODE_W-1:0] CHAR_LOWER_B = CHAR_LOWER_A + 21'd1;
	localparam logic [CODE_W-1:0] CHAR_LOWER_Z = CHAR_UPPER_Z + CASE_OFFSET;
	localparam logic [CODE_W-1:0] CHAR_AT      = 21'h40;
	localparam logic [CODE_W-1:0] CHAR_BRACKET = 21'h5B;
	localparam logic [CODE_W-1:0] CHAR_ALPHA   = 21'h3B1;
	localparam logic [CODE_W-1:0] CODE_NEWLINE = 21'h0A;
	localparam logic [CODE_W-1:0] CODE_MAX     = 21'h10FFFF;

	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned TARGET_ITEMS  = 850;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [PIDX_W-1:0]    pattern_index;
		logic [CODE_W-1:0]    code;
		logic                 has_box;
		logic signed [CW-1:0] left;
		logic signed [CW-1:0] top;
		logic signed [CW-1:0] right;
		logic signed [CW-1:0] bottom;
	} glyph_item_t;

	typedef struct packed {
		logic signed [CW-1:0] left;
		logic signed [CW-1:0] top;
		logic signed [CW-1:0] right;
		logic signed [CW-1:0] bottom;
		logic                 box_found;
	} match_box_t;

	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic signed [CW-1:0] left;
		logic signed [CW-1:0] top;
		logic signed [CW-1:0] right;
		logic signed [CW-1:0] bottom;
		logic                 present;
	} window_slot_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cfts_glyph_if glyph_bus ();
	cfts_match_if match_bus ();

	casefold_text_search_boxes u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.glyph_in (glyph_bus),
		.match_out(match_bus)
	);

	// search model state
	logic [CODE_W-1:0] pattern_codes [WIN];
	window_slot_t      glyph_window [WIN];
	int unsigned       page_glyphs;
	int unsigned       glyphs_since_match;
	logic [PLEN_W-1:0] active_length;
	match_box_t        pending_matches [$];

	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          sender_gaps = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	logic [15:0] ready_pattern = 16'hB5A7;
	int unsigned quiet_cycles = 0;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [CODE_W-1:0] to_lower(input logic [CODE_W-1:0] c);
		return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
	endfunction

	function automatic logic [CODE_W-1:0] mixed_case(input logic [CODE_W-1:0] c);
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z && $urandom_range(0, 1) == 1) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	// small alphabet with the characters around the folding range
	function automatic logic [CODE_W-1:0] alphabet_char();
		case ($urandom_range(0, 5))
		0: return CHAR_LOWER_A;
		1: return CHAR_LOWER_B;
		2: return CHAR_LOWER_Z;
		3: return CHAR_AT;
		4: return CHAR_BRACKET;
		default: return CHAR_ALPHA;
		endcase
	endfunction

	function automatic glyph_item_t random_item(input logic [MODE_W-1:0] mode);
		glyph_item_t g;
		g.mode          = mode;
		g.pattern_index = PIDX_W'($urandom);
		g.code          = CODE_W'($urandom_range(0, CODE_MAX));
		g.has_box       = 1'($urandom);
		g.left          = CW'($urandom);
		g.top           = CW'($urandom);
		g.right         = CW'($urandom);
		g.bottom        = CW'($urandom);
		return g;
	endfunction

	function automatic glyph_item_t pattern_item(input int unsigned idx,
		input logic [CODE_W-1:0] c);
		glyph_item_t g;
		g               = random_item(MODE_PATTERN);
		g.pattern_index = PIDX_W'(idx);
		g.code          = c;
		return g;
	endfunction

	function automatic glyph_item_t text_glyph(input logic [CODE_W-1:0] c, input logic box,
		input int l, input int t, input int r, input int b);
		glyph_item_t g;
		g         = random_item(MODE_TEXT);
		g.code    = c;
		g.has_box = box;
		g.left    = CW'(l);
		g.top     = CW'(t);
		g.right   = CW'(r);
		g.bottom  = CW'(b);
		return g;
	endfunction

	// mostly small valid boxes, some full-range, degenerate or missing ones
	function automatic glyph_item_t boxed_glyph(input logic [CODE_W-1:0] c);
		glyph_item_t g;
		int x;
		int y;
		g         = random_item(MODE_TEXT);
		g.code    = c;
		g.has_box = 1'b1;
		x         = int'($urandom_range(0, 40000)) - 20000;
		y         = int'($urandom_range(0, 40000)) - 20000;
		case ($urandom_range(0, 9))
		0: begin
			// keep the random full-range corners
		end
		1: begin
			g.left   = CW'(x);
			g.top    = CW'(y);
			g.right  = CW'(x + int'($urandom_range(0, 400)) - 200);
			g.bottom = CW'(y);
		end
		2: begin
			g.has_box = 1'b0;
			g.left    = CW'(x);
			g.top     = CW'(y);
			g.right   = CW'(x + 300);
			g.bottom  = CW'(y + 300);
		end
		default: begin
			g.left   = CW'(x);
			g.top    = CW'(y);
			g.right  = CW'(x + int'($urandom_range(1, 3000)));
			g.bottom = CW'(y + int'($urandom_range(1, 3000)));
		end
		endcase
		return g;
	endfunction

	task automatic clear_page();
		for (int i = 0; i < WIN; i++) glyph_window[i] = '0;
		page_glyphs        = 0;
		glyphs_since_match = WIN;
	endtask

	task automatic predict_search_step(input glyph_item_t g);
		window_slot_t slot;
		int unsigned  len;
		bit           hit;
		match_box_t   m;
		case (g.mode)
		MODE_PATTERN: pattern_codes[g.pattern_index] = to_lower(g.code);
		MODE_PAGE: clear_page();
		MODE_TEXT: begin
			slot.code    = to_lower(g.code);
			slot.left    = g.left;
			slot.top     = g.top;
			slot.right   = g.right;
			slot.bottom  = g.bottom;
			slot.present = g.has_box && (g.left < g.right) && (g.top < g.bottom);
			for (int i = 0; i < WIN - 1; i++) glyph_window[i] = glyph_window[i + 1];
			glyph_window[WIN - 1] = slot;
			if (page_glyphs < WIN) page_glyphs++;
			if (glyphs_since_match < WIN) glyphs_since_match++;
			len = (active_length > WIN) ? WIN : active_length;
			if (len != 0 && page_glyphs >= len && glyphs_since_match >= len) begin
				hit = 1'b1;
				for (int k = 0; k < len; k++) begin
					if (glyph_window[WIN - len + k].code != pattern_codes[k]) hit = 1'b0;
				end
				if (hit) begin
					glyphs_since_match = 0;
					m = '0;
					for (int k = WIN - len; k < WIN; k++) begin
						if (!glyph_window[k].present) continue;
						if (!m.box_found) begin
							m.left      = glyph_window[k].left;
							m.top       = glyph_window[k].top;
							m.right     = glyph_window[k].right;
							m.bottom    = glyph_window[k].bottom;
							m.box_found = 1'b1;
						end else begin
							if (glyph_window[k].left < m.left) m.left = glyph_window[k].left;
							if (glyph_window[k].top < m.top) m.top = glyph_window[k].top;
							if (glyph_window[k].right > m.right) m.right = glyph_window[k].right;
							if (glyph_window[k].bottom > m.bottom) m.bottom = glyph_window[k].bottom;
						end
					end
					pending_matches.insert(pending_matches.size(), m);
				end
			end
		end
		default: ;
		endcase
	endtask

	// sender runs in bursts; a new burst may open with an idle gap
	task automatic send_item(input glyph_item_t g);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = sender_gaps ? $urandom_range(1, 8) : 0;
			if (gap != 0) begin
				glyph_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		glyph_bus.valid         <= 1'b1;
		glyph_bus.mode          <= g.mode;
		glyph_bus.pattern_index <= g.pattern_index;
		glyph_bus.code          <= g.code;
		glyph_bus.has_box       <= g.has_box;
		glyph_bus.left          <= g.left;
		glyph_bus.top           <= g.top;
		glyph_bus.right         <= g.right;
		glyph_bus.bottom        <= g.bottom;
		do @(posedge clk); while (!glyph_bus.ready);
		predict_search_step(g);
		items_sent++;
	endtask

	task automatic glyph_idle();
		glyph_bus.valid <= 1'b0;
		burst_left = 0;
	endtask

	// register writes only once all matches are out and the block has settled
	task automatic write_pattern_length(input logic [PLEN_W-1:0] len);
		glyph_idle();
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PATTERN_LENGTH_ADDR;
		pwdata  <= APB_DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		active_length = len;
	endtask

	task automatic compare_field(input string name, input logic signed [CW-1:0] want,
		input logic signed [CW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		match_box_t want;
		if (arst_n && match_bus.valid && match_bus.ready) begin
			if (pending_matches.size() == 0) begin
				$error("match transfer with none expected: box %0d %0d %0d %0d found %0b",
					match_bus.match_left, match_bus.match_top, match_bus.match_right,
					match_bus.match_bottom, match_bus.box_found);
				error_count++;
			end else begin
				want = pending_matches.pop_front();
				compare_field("match_left", want.left, match_bus.match_left);
				compare_field("match_top", want.top, match_bus.match_top);
				compare_field("match_right", want.right, match_bus.match_right);
				compare_field("match_bottom", want.bottom, match_bus.match_bottom);
				compare_field("box_found", CW'(want.box_found), CW'(match_bus.box_found));
			end
		end
	end

	// receiver: rotating stall pattern, plus long hold-offs on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left       <= hold_left - 1;
				match_bus.ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served    <= holds_served + 1;
				hold_left       <= HOLD_CYCLES;
				match_bus.ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) begin
					ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF :
						(16'($urandom) | 16'h0001);
				end else begin
					ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
				end
				match_bus.ready <= ready_pattern[0];
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (glyph_bus.valid && glyph_bus.ready) ||
			(match_bus.valid && match_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$error("no transfer for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// length still at its reset value: nothing may match
	task automatic test_matching_disabled();
		send_item(text_glyph(CHAR_LOWER_A, 1'b1, 0, 0, 512, 512));
		send_item(text_glyph(CODE_NEWLINE, 1'b0, 0, 0, 0, 0));
		send_item(random_item(MODE_UNUSED));
		send_item(random_item(MODE_PAGE));
	endtask

	// pattern holds code zero, so the cleared window would match a too-short page
	task automatic test_fold_and_short_page();
		write_pattern_length(PLEN_W'(3));
		send_item(pattern_item(0, 21'h0));
		send_item(pattern_item(1, CHAR_UPPER_Z));
		send_item(pattern_item(2, CODE_MAX));
		send_item(random_item(MODE_PAGE));
		send_item(text_glyph(CHAR_LOWER_Z, 1'b1, 10, 10, 20, 20));
		send_item(text_glyph(CODE_MAX, 1'b1, 30, 10, 40, 20));
		send_item(text_glyph(21'h0, 1'b0, -100, -100, 100, 100));
		send_item(text_glyph(CHAR_UPPER_Z, 1'b1, -8388608, -8388608, 0, 0));
		send_item(text_glyph(CODE_MAX, 1'b1, 0, 0, 8388607, 8388607));
	endtask

	// leftmost non-overlapping matches, empty and missing boxes
	task automatic test_overlap_and_empty_boxes();
		write_pattern_length(PLEN_W'(2));
		send_item(pattern_item(0, CHAR_LOWER_A));
		send_item(pattern_item(1, CHAR_UPPER_A));
		send_item(random_item(MODE_PAGE));
		send_item(text_glyph(CHAR_UPPER_A, 1'b1, 5, 5, 5, 9));
		send_item(text_glyph(CHAR_LOWER_A, 1'b1, 10, 20, 5, 30));
		send_item(text_glyph(CHAR_LOWER_A, 1'b0, 0, 0, 50, 50));
		send_item(text_glyph(CHAR_UPPER_A, 1'b1, 100, 200, 300, 400));
		send_item(text_glyph(CHAR_LOWER_A, 1'b1, 1, 1, 2, 2));
		send_item(text_glyph(CODE_NEWLINE, 1'b0, 0, 0, 0, 0));
		send_item(text_glyph(CHAR_LOWER_A, 1'b1, 1, 1, 2, 2));
	endtask

	// one-character pattern hits on every glyph while the receiver holds off
	task automatic test_result_backpressure();
		write_pattern_length(PLEN_W'(1));
		sender_gaps = 1'b0;
		send_item(pattern_item(0, CHAR_LOWER_A));
		hold_requests++;
		for (int i = 0; i < 60; i++) send_item(boxed_glyph(mixed_case(CHAR_LOWER_A)));
	endtask

	task automatic run_search_phase(input logic [PLEN_W-1:0] len, input int unsigned glyphs);
		int unsigned plen;
		int unsigned sent;
		int unsigned roll;
		int unsigned broken_at;
		write_pattern_length(len);
		plen        = (len > WIN) ? WIN : len;
		sender_gaps = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < plen; i++) send_item(pattern_item(i, mixed_case(alphabet_char())));
		send_item(random_item(MODE_PAGE));
		sent = 0;
		while (sent < glyphs) begin
			roll = $urandom_range(0, 99);
			if (roll < 45 && plen != 0) begin
				// copy of the pattern, now and then with one character broken
				broken_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen - 1) : plen;
				for (int k = 0; k < plen; k++) begin
					send_item(boxed_glyph(mixed_case(
						(k == broken_at) ? alphabet_char() : pattern_codes[k])));
				end
				sent += plen;
			end else if (roll < 80) begin
				send_item(boxed_glyph(mixed_case(alphabet_char())));
				sent++;
			end else if (roll < 86) begin
				send_item(text_glyph(CODE_NEWLINE, 1'b0, 0, 0, 0, 0));
				sent++;
			end else if (roll < 89) begin
				send_item(random_item(MODE_PAGE));
			end else if (roll < 94) begin
				send_item(random_item(MODE_TEXT));
				sent++;
			end else if (roll < 96) begin
				send_item(random_item(MODE_UNUSED));
			end else begin
				send_item(pattern_item($urandom_range(0, WIN - 1), mixed_case(alphabet_char())));
			end
		end
	endtask

	task automatic test_random_stream();
		logic [PLEN_W-1:0] len;
		int unsigned       phase;
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			case (phase)
			0: len = PLEN_W'(1);
			1: len = PLEN_W'(32);
			2: len = PLEN_W'(63);
			3: len = PLEN_W'(2);
			4: len = PLEN_W'(33);
			5: len = PLEN_W'(0);
			6: len = PLEN_W'(4);
			default: begin
				case ($urandom_range(0, 9))
				0: len = PLEN_W'($urandom_range(1, 32));
				1: len = PLEN_W'($urandom_range(0, 63));
				default: len = PLEN_W'($urandom_range(1, 5));
				endcase
			end
			endcase
			run_search_phase(len, $urandom_range(40, 90));
			phase++;
		end
	endtask

	initial begin
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		glyph_bus.valid         = 1'b0;
		glyph_bus.mode          = MODE_PAGE;
		glyph_bus.pattern_index = '0;
		glyph_bus.code          = '0;
		glyph_bus.has_box       = 1'b0;
		glyph_bus.left          = '0;
		glyph_bus.top           = '0;
		glyph_bus.right         = '0;
		glyph_bus.bottom        = '0;
		match_bus.ready         = 1'b0;
		for (int i = 0; i < WIN; i++) pattern_codes[i] = '0;
		active_length = '0;
		clear_page();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_matching_disabled();
		test_fold_and_short_page();
		test_overlap_and_empty_boxes();
		test_result_backpressure();
		test_random_stream();

		glyph_idle();
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_matches.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
